[hdl/assert_macros.svh]
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/xybsg_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xybsg_pkg: shared types and constants
// Beat structs, command codes, config register indices and period unit types.
// ---------------------------------------------------------------------------
package xybsg_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_MOVE  = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  localparam logic [1:0] REG_STEPS_PER_MM = 2'd0;
  localparam logic [1:0] REG_PULSE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_RAPID_DELAY  = 2'd2;

  localparam int unsigned SettleTicks = 5;
  localparam int unsigned UsPerMin    = 60000000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic [15:0]        feed_speed;
  } in_beat_t;

  typedef struct packed {
    logic               step_x;
    logic               step_y;
    logic               dir_x;
    logic               dir_y;
    logic               busy_res;
    logic               move_done;
    logic signed [23:0] position_x;
    logic signed [23:0] position_y;
    logic               stop_active;
  } out_beat_t;

  // request to the period unit
  typedef struct packed {
    logic        start;
    logic [23:0] abs_dx;
    logic [23:0] abs_dy;
    logic [15:0] feed;
    logic [11:0] step_scale;
    logic [9:0]  pulse_width;
  } per_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] period;
  } per_rsp_t;

endpackage

[hdl/xybsg_period_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xybsg_period_unit: step period calculator
// Shift-add squares, bit-pair root, two multiplies, restoring divide, clamp.
// One shared add/subtract datapath stepped by a small sequencer.
// ---------------------------------------------------------------------------
module xybsg_period_unit
  import xybsg_pkg::*;
#(
  parameter int unsigned MaxPeriodUs = 50000
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  per_req_t req_i,
  output per_rsp_t rsp_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQX  = 7'b0000010,
    S_SQY  = 7'b0000100,
    S_ROOT = 7'b0001000,
    S_NUM  = 7'b0010000,
    S_DEN  = 7'b0100000,
    S_DIV  = 7'b1000000
  } st_e;

  st_e         st_q, st_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [49:0] sq_q, sq_d;          // dx^2+dy^2, radicand shifted out by the root
  logic [24:0] root_q, root_d;
  logic [50:0] rem_q, rem_d;        // root remainder workspace
  logic [50:0] num_q, num_d;        // root * 60e6, later quotient shift reg
  logic [51:0] den_q, den_d;        // spm*feed*n
  logic [51:0] mcand_q, mcand_d;
  logic [25:0] mplier_q, mplier_d;
  logic [52:0] drem_q, drem_d;
  logic [23:0] n_q;
  logic [15:0] period_q, period_d;
  logic        done_q, done_d;

  // shared adder
  logic [52:0] add_a, add_b, add_s;
  logic        add_sub;
  assign add_s = add_sub ? (add_a - add_b) : (add_a + add_b);

  logic [50:0] q_full;
  logic [50:0] lo_lim;
  logic [27:0] root_trial;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; sq_d = sq_q; root_d = root_q; rem_d = rem_q;
    num_d = num_q; den_d = den_q; mcand_d = mcand_q; mplier_d = mplier_q;
    drem_d = drem_q; period_d = period_q; done_d = 1'b0;
    add_a = '0; add_b = '0; add_sub = 1'b0;
    root_trial = '0;
    q_full = '0;
    lo_lim = 51'(req_i.pulse_width) + 51'(SettleTicks);
    unique case (st_q)
      S_IDLE: begin
        if (req_i.start) begin
          sq_d = '0;
          mcand_d = 52'(req_i.abs_dx);
          mplier_d = 26'(req_i.abs_dx);
          cnt_d = 6'd24;
          st_d = S_SQX;
        end
      end
      S_SQX, S_SQY: begin
        add_a = 53'(sq_q); add_b = 53'(mcand_q);
        if (mplier_q[0]) sq_d = add_s[49:0];
        mcand_d = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          if (st_q == S_SQX) begin
            mcand_d = 52'(req_i.abs_dy);
            mplier_d = 26'(req_i.abs_dy);
            cnt_d = 6'd24;
            st_d = S_SQY;
          end else begin
            rem_d = '0; root_d = '0; cnt_d = 6'd25;
            st_d = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        // one result bit per cycle from the top bit pair of sq
        rem_d = {rem_q[48:0], sq_q[49:48]};
        sq_d = {sq_q[47:0], 2'b00};
        root_trial = {1'b0, root_q, 2'b01};
        add_a = 53'({rem_q[48:0], sq_q[49:48]}); add_b = 53'(root_trial);
        add_sub = 1'b1;
        if (!add_s[52]) begin
          rem_d = add_s[50:0];
          root_d = {root_q[23:0], 1'b1};
        end else begin
          root_d = {root_q[23:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          num_d = '0;
          mcand_d = 52'(root_d);
          mplier_d = 26'(UsPerMin);
          cnt_d = 6'd26;
          st_d = S_NUM;
        end
      end
      S_NUM: begin
        add_a = 53'(num_q); add_b = 53'(mcand_q);
        if (mplier_q[0]) num_d = add_s[50:0];
        mcand_d = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          den_d = '0;
          mcand_d = 52'(28'(req_i.step_scale) * 28'(req_i.feed));
          mplier_d = 26'(n_q);
          cnt_d = 6'd24;
          st_d = S_DEN;
        end
      end
      S_DEN: begin
        add_a = 53'(den_q); add_b = 53'(mcand_q);
        if (mplier_q[0]) den_d = add_s[51:0];
        mcand_d = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          drem_d = '0; cnt_d = 6'd51;
          st_d = S_DIV;
        end
      end
      S_DIV: begin
        add_a = {drem_q[51:0], num_q[50]}; add_b = 53'(den_q);
        add_sub = 1'b1;
        drem_d = {drem_q[51:0], num_q[50]};
        num_d = {num_q[49:0], 1'b0};
        if (!add_s[52] || drem_q[51]) begin
          drem_d = add_s;
          num_d[0] = 1'b1;
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          q_full = (den_q == '0) ? '1 : num_d;
          if (q_full < lo_lim) q_full = lo_lim;
          if (q_full > 51'(MaxPeriodUs)) q_full = 51'(MaxPeriodUs);
          period_d = q_full[15:0];
          done_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d; root_q <= root_d; rem_q <= rem_d; num_q <= num_d;
    den_q <= den_d; mcand_q <= mcand_d; mplier_q <= mplier_d;
    drem_q <= drem_d; period_q <= period_d;
    if (st_q == S_IDLE && req_i.start)
      n_q <= (req_i.abs_dx > req_i.abs_dy) ? req_i.abs_dx : req_i.abs_dy;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.period = period_q;

endmodule

[hdl/xy_bresenham_step_generator_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xy_bresenham_step_generator_core: two-axis step/dir pulse generator
// Bresenham interpolation with per-move step period from feed rate.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_stall_o) carries one command beat: tick,
//    move, set stop or clear stop. Every input beat yields one output beat
//    on out_valid_o/out_stall_i holding pin levels, position and status.
//  - Tick, stop and clear commands pass through exec to the output beat.
//  - A move with nonzero feed that starts a real move runs the period unit:
//    square steps, root, multiply, multiply and divide, after exec and start
//    and before done and the output beat, all on one shared adder. Rapid
//    moves go from exec straight to the output beat.
//  - One beat in flight: the next input is taken the cycle after the output
//    beat leaves.
//  - Config writes via cfg_we_i/cfg_idx_i/cfg_data_i, only while idle.
//  - Reset clears position, stop latch and move state; registers return to
//    80 steps/mm, 5 us pulse, 500 us rapid delay.
//  - A stalled output beat holds; no new input is taken until it is sent.
// ---------------------------------------------------------------------------
module xy_bresenham_step_generator_core
  import xybsg_pkg::*;
#(
  parameter int unsigned POS_BITS      = 24,
  parameter int unsigned MAX_PERIOD_US = 50000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_EXEC = 4'b0010,
    C_WAIT = 4'b0100,
    C_OUT  = 4'b1000
  } ctl_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_SETTLE = 4'b0010,
    PH_HIGH   = 4'b0100,
    PH_LOW    = 4'b1000
  } ph_e;

  // targets are 24 bit; narrower positions wrap, wider ones change nothing
  localparam int unsigned WrapBits = (POS_BITS < 24) ? POS_BITS : 24;

  ctl_e ctl_q, ctl_d;
  ph_e  ph_q, ph_d;

  logic [11:0] spm_q;
  logic [9:0]  pw_q;
  logic [15:0] rapid_q;

  in_beat_t    cmd_q;
  logic signed [23:0] pos_x_q, pos_y_q, goal_x_q, goal_y_q;
  logic signed [23:0] pos_x_d, pos_y_d, goal_x_d, goal_y_d;
  logic        stop_q, stop_d;
  logic [23:0] adx_q, ady_q, adx_d, ady_d, left_q, left_d;
  logic [24:0] acc_x_q, acc_y_q, acc_x_d, acc_y_d;
  logic [15:0] period_q, period_d, tick_q, tick_d;
  logic [1:0]  dir_q, dir_d, pin_q, pin_d;
  logic        done_q, done_d;
  logic        pend_q, pend_d;   // period unit start still to be issued

  per_req_t req;
  per_rsp_t rsp;

  xybsg_period_unit #(.MaxPeriodUs(MAX_PERIOD_US)) u_period (
    .clk_i, .rst_ni, .req_i(req), .rsp_o(rsp)
  );

  // wrapped targets and deltas
  logic signed [WrapBits-1:0] tx_w, ty_w;
  logic signed [24:0] tx, ty, dx, dy;
  logic [23:0] n_cur;
  logic [24:0] ax_sum, ay_sum;

  always_comb begin
    tx_w = cmd_q.target_x[WrapBits-1:0];
    ty_w = cmd_q.target_y[WrapBits-1:0];
    tx = 25'(tx_w);
    ty = 25'(ty_w);
    dx = tx - 25'(pos_x_q);
    dy = ty - 25'(pos_y_q);
  end

  assign n_cur  = (adx_q > ady_q) ? adx_q : ady_q;
  assign ax_sum = acc_x_q + 25'(adx_q);
  assign ay_sum = acc_y_q + 25'(ady_q);

  always_comb begin
    ctl_d = ctl_q; ph_d = ph_q;
    pos_x_d = pos_x_q; pos_y_d = pos_y_q; goal_x_d = goal_x_q; goal_y_d = goal_y_q;
    stop_d = stop_q; adx_d = adx_q; ady_d = ady_q; left_d = left_q;
    acc_x_d = acc_x_q; acc_y_d = acc_y_q; period_d = period_q; tick_d = tick_q;
    dir_d = dir_q; pin_d = pin_q; done_d = done_q; pend_d = pend_q;
    req = '0;
    req.abs_dx = adx_q; req.abs_dy = ady_q; req.feed = cmd_q.feed_speed;
    req.step_scale = spm_q; req.pulse_width = pw_q;
    unique case (ctl_q)
      C_IDLE: begin
        if (in_valid_i) ctl_d = C_EXEC;
      end
      C_EXEC: begin
        done_d = 1'b0;
        ctl_d = C_OUT;
        unique case (cmd_e'(cmd_q.cmd))
          CMD_STOP:  stop_d = 1'b1;
          CMD_CLEAR: stop_d = 1'b0;
          CMD_MOVE: begin
            if (ph_q == PH_IDLE && (dx != '0 || dy != '0)) begin
              dir_d = {~dy[24], ~dx[24]};
              adx_d = dx[24] ? 24'(-dx) : dx[23:0];
              ady_d = dy[24] ? 24'(-dy) : dy[23:0];
              left_d = (adx_d > ady_d) ? adx_d : ady_d;
              goal_x_d = tx[23:0]; goal_y_d = ty[23:0];
              acc_x_d = '0; acc_y_d = '0; pin_d = '0; tick_d = '0;
              ph_d = PH_SETTLE;
              if (cmd_q.feed_speed == '0) begin
                period_d = rapid_q;
              end else begin
                pend_d = 1'b1;
                ctl_d = C_WAIT;
              end
            end
          end
          default: begin
            priority case (ph_q)
              PH_SETTLE, PH_LOW: begin
                if ((ph_q == PH_SETTLE && tick_q < 16'(SettleTicks)) ||
                    (ph_q == PH_LOW && tick_q < period_q)) begin
                  tick_d = tick_q + 16'd1;
                end else if (stop_q || left_q == '0) begin
                  if (!stop_q) begin
                    pos_x_d = goal_x_q; pos_y_d = goal_y_q;
                  end
                  ph_d = PH_IDLE; pin_d = '0; tick_d = '0; done_d = 1'b1;
                end else begin
                  left_d = left_q - 24'd1;
                  pin_d = '0;
                  acc_x_d = ax_sum; acc_y_d = ay_sum;
                  if (ax_sum >= 25'(n_cur)) begin
                    acc_x_d = ax_sum - 25'(n_cur); pin_d[0] = 1'b1;
                  end
                  if (ay_sum >= 25'(n_cur)) begin
                    acc_y_d = ay_sum - 25'(n_cur); pin_d[1] = 1'b1;
                  end
                  ph_d = PH_HIGH; tick_d = 16'd1;
                end
              end
              PH_HIGH: begin
                if (tick_q < 16'(pw_q)) tick_d = tick_q + 16'd1;
                else begin
                  pin_d = '0; ph_d = PH_LOW; tick_d = 16'd1;
                end
              end
              default: ;
            endcase
          end
        endcase
      end
      C_WAIT: begin
        req.start = pend_q;
        pend_d = 1'b0;
        if (rsp.done) begin
          period_d = rsp.period;
          ctl_d = C_OUT;
        end
      end
      C_OUT: begin
        if (!out_stall_i) ctl_d = C_IDLE;
      end
      default: ctl_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= C_IDLE; ph_q <= PH_IDLE;
      spm_q <= 12'd80; pw_q <= 10'd5; rapid_q <= 16'd500;
      pos_x_q <= '0; pos_y_q <= '0; goal_x_q <= '0; goal_y_q <= '0;
      stop_q <= 1'b0; adx_q <= '0; ady_q <= '0; left_q <= '0;
      acc_x_q <= '0; acc_y_q <= '0; period_q <= '0; tick_q <= '0;
      dir_q <= '0; pin_q <= '0; done_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      ctl_q <= ctl_d; ph_q <= ph_d;
      pos_x_q <= pos_x_d; pos_y_q <= pos_y_d;
      goal_x_q <= goal_x_d; goal_y_q <= goal_y_d;
      stop_q <= stop_d; adx_q <= adx_d; ady_q <= ady_d; left_q <= left_d;
      acc_x_q <= acc_x_d; acc_y_q <= acc_y_d; period_q <= period_d;
      tick_q <= tick_d; dir_q <= dir_d; pin_q <= pin_d;
      done_q <= done_d; pend_q <= pend_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_STEPS_PER_MM: spm_q <= cfg_data_i[11:0];
          REG_PULSE_WIDTH:  pw_q <= cfg_data_i[9:0];
          REG_RAPID_DELAY:  rapid_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_q == C_IDLE && in_valid_i) cmd_q <= in_data_i;
  end

  assign in_stall_o = (ctl_q != C_IDLE);
  assign out_valid_o = (ctl_q == C_OUT);

  always_comb begin
    out_data_o.step_x = pin_q[0];
    out_data_o.step_y = pin_q[1];
    out_data_o.dir_x = dir_q[0];
    out_data_o.dir_y = dir_q[1];
    out_data_o.busy_res = (ph_q != PH_IDLE);
    out_data_o.move_done = done_q;
    out_data_o.position_x = pos_x_q;
    out_data_o.position_y = pos_y_q;
    out_data_o.stop_active = stop_q;
  end

`include "assert_macros.svh"

  `ASSERT_IMP(a_pins_idle, ph_q == PH_IDLE, pin_q == 2'b00)
  `ASSERT_IMP(a_out_one_ctl, out_valid_o, in_stall_o)
  `ASSERT_NXT(a_done_idle, ctl_q == C_EXEC && done_d, ph_q == PH_IDLE)

endmodule
